// File: sv/sidt_pkg.sv
`default_nettype none
package sidt_pkg;

	localparam int NUM_DIGITS      = 10;
	localparam int VALUE_W         = 32;
	localparam int BCD_DIGITS      = 10;
	localparam int BCD_W           = 4 * BCD_DIGITS;
	localparam int COUNT_W         = 4;
	localparam int STEPS_PER_STAGE = 8;
	localparam int DABBLE_STAGES   = VALUE_W / STEPS_PER_STAGE;
	localparam int SHIFT_W         = BCD_W + VALUE_W;

	// Work in flight between the conversion stages.
	typedef struct packed {
		logic               negative;
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
	} dd_t;

	// One shift-add-3 step over the joined BCD and binary register.
	function automatic logic [SHIFT_W-1:0] dabble_step(input logic [SHIFT_W-1:0] x);
		logic [SHIFT_W-1:0] y;
		y = x;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (y[VALUE_W + 4*i +: 4] >= 4'd5) begin
				y[VALUE_W + 4*i +: 4] = y[VALUE_W + 4*i +: 4] + 4'd3;
			end
		end
		return {y[SHIFT_W-2:0], 1'b0};
	endfunction

endpackage
`default_nettype wire

// File: sv/sidt_in_if.sv
`default_nettype none
interface sidt_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [sidt_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

// File: sv/sidt_out_if.sv
`default_nettype none
interface sidt_out_if;
	logic                            valid;
	logic                            ready;
	logic                            negative;
	logic [sidt_pkg::BCD_W-1:0]      digits_bcd;
	logic [sidt_pkg::COUNT_W-1:0]    digit_count;
	logic                            overflow;

	modport source (output valid, output negative, output digits_bcd,
		output digit_count, output overflow, input ready);
	modport sink (input valid, input negative, input digits_bcd,
		input digit_count, input overflow, output ready);
endinterface
`default_nettype wire

// File: sv/sidt_dabble_stage.sv
`default_nettype none
// Eight double-dabble steps followed by the stage register.
module sidt_dabble_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          valid_i,
	input  wire sidt_pkg::dd_t dd_i,
	output logic               valid_q,
	output sidt_pkg::dd_t      dd_q
);

	logic [sidt_pkg::SHIFT_W-1:0] shift_d;

	always_comb begin
		shift_d = {dd_i.bcd, dd_i.bin};
		for (int s = 0; s < sidt_pkg::STEPS_PER_STAGE; s++) begin
			shift_d = sidt_pkg::dabble_step(shift_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_q.negative <= dd_i.negative;
			dd_q.bcd      <= shift_d[sidt_pkg::SHIFT_W-1:sidt_pkg::VALUE_W];
			dd_q.bin      <= shift_d[sidt_pkg::VALUE_W-1:0];
		end
	end

endmodule
`default_nettype wire

// File: sv/signed_int_to_decimal_digits_top.sv
`default_nettype none
// Six register stages: stage 1, the four double-dabble stages and the output register.
// Throughput: one request per cycle unless dout stalls; the pipeline advances
// whenever the output register is empty or taken, so a stall on dout holds every stage.
// The four double-dabble stages each handle 8 of the 32 magnitude bits.
// Reset clears all valid bits at once; no clearing pass is needed.
module signed_int_to_decimal_digits_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sidt_in_if.sink     din,
	sidt_out_if.source  dout
);

	logic          en;
	logic          valid_s1;
	sidt_pkg::dd_t dd_s1;
	logic          valid_st [sidt_pkg::DABBLE_STAGES+1];
	sidt_pkg::dd_t dd_st    [sidt_pkg::DABBLE_STAGES+1];

	logic                            valid_s6;
	logic                            negative_s6;
	logic [sidt_pkg::BCD_W-1:0]      bcd_s6;
	logic [sidt_pkg::COUNT_W-1:0]    count_s6;
	logic                            overflow_s6;

	logic                            in_neg;
	logic [sidt_pkg::VALUE_W-1:0]    in_mag;
	sidt_pkg::dd_t                   last_dd;
	logic [sidt_pkg::COUNT_W-1:0]    count_d;
	logic [sidt_pkg::BCD_W-1:0]      bcd_d;
	logic                            overflow_d;

	assign en        = !valid_s6 || dout.ready;
	assign din.ready = en;

	// Stage 1: sign and magnitude.
	assign in_neg = din.value[sidt_pkg::VALUE_W-1];
	assign in_mag = in_neg ? (sidt_pkg::VALUE_W'(0) - sidt_pkg::VALUE_W'(din.value))
	                       : sidt_pkg::VALUE_W'(din.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s1.negative <= in_neg;
			dd_s1.bcd      <= '0;
			dd_s1.bin      <= in_mag;
		end
	end

	assign valid_st[0] = valid_s1;
	assign dd_st[0]    = dd_s1;

	for (genvar g = 0; g < sidt_pkg::DABBLE_STAGES; g++) begin : g_dabble
		sidt_dabble_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (valid_st[g]),
			.dd_i    (dd_st[g]),
			.valid_q (valid_st[g+1]),
			.dd_q    (dd_st[g+1])
		);
	end

	// Final stage: digit count, store width and overflow.
	assign last_dd = dd_st[sidt_pkg::DABBLE_STAGES];

	always_comb begin
		count_d = sidt_pkg::COUNT_W'(1);
		bcd_d   = '0;
		for (int k = 0; k < sidt_pkg::BCD_DIGITS; k++) begin
			if (last_dd.bcd[4*k +: 4] != 4'd0) begin
				count_d = sidt_pkg::COUNT_W'(k + 1);
			end
			if (k < sidt_pkg::NUM_DIGITS) begin
				bcd_d[4*k +: 4] = last_dd.bcd[4*k +: 4];
			end
		end
		overflow_d = {1'b0, count_d} > (sidt_pkg::COUNT_W + 1)'(sidt_pkg::NUM_DIGITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_st[sidt_pkg::DABBLE_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			negative_s6 <= last_dd.negative;
			bcd_s6      <= bcd_d;
			count_s6    <= count_d;
			overflow_s6 <= overflow_d;
		end
	end

	assign dout.valid       = valid_s6;
	assign dout.negative    = negative_s6;
	assign dout.digits_bcd  = bcd_s6;
	assign dout.digit_count = count_s6;
	assign dout.overflow    = overflow_s6;

endmodule
`default_nettype wire
